// ----- design/poisson_disk_dart_check_defines.svh -----
// Assertion macros shared by the sampler modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef POISSON_DISK_DART_CHECK_DEFINES_SVH
`define POISSON_DISK_DART_CHECK_DEFINES_SVH
`ifndef SYNTHESIS
`define PDD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdd: same-cycle check failed");
`define PDD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdd: next-cycle check failed");
`else
`define PDD_ASSERT_NOW(name, ante, cons)
`define PDD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- design/pdd_pkg.sv -----
`default_nettype none
package pdd_pkg;

  localparam int GRID_DIM   = 64;
  localparam int COORD_BITS = 16;

  localparam int COORD_W   = 16;
  localparam int LEN_W     = 11;
  localparam int LIM_W     = 18;
  localparam int IDX_W     = 13;
  localparam int CELL_BITS = $clog2(GRID_DIM);
  localparam int CELLS     = GRID_DIM * GRID_DIM;
  localparam int ADDR_BITS = $clog2(CELLS);
  localparam int ENTRY_W   = 1 + 2 * COORD_BITS;
  localparam int DIV_STEPS = (COORD_BITS + 1) / 2;
  localparam int QUO_W     = 2 * DIV_STEPS;
  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int SUM_W     = SQ_W + 1;
  localparam int R2_W      = 2 * LEN_W;
  localparam int NBR_W     = 3;
  localparam int NBR_OFS   = 2;
  localparam int DRAIN_CYC = 2;

  localparam logic [NBR_W-1:0] NBR_LAST = NBR_W'(2 * NBR_OFS);
  localparam logic [LIM_W-1:0] REJ_MAX  = '1;
  localparam logic [IDX_W-1:0] CNT_MAX  = '1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIDE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_LIMIT = 2'd2;

  localparam logic [LEN_W-1:0] RADIUS_RST    = 11'd1280;
  localparam logic [LEN_W-1:0] CELL_SIDE_RST = 11'd905;
  localparam logic [LIM_W-1:0] LIMIT_RST     = 18'd150000;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_CAND  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] cand_x;
    logic [COORD_W-1:0] cand_y;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic [IDX_W-1:0] point_index;
    logic [LIM_W-1:0] reject_run;
    logic             done_res;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] radius_fp;
    logic [LEN_W-1:0] cell_side_fp;
    logic [LIM_W-1:0] reject_limit;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic                 zero;
    logic                 refuse;
    logic                 div_step;
    logic                 scan;
    logic [NBR_W-1:0]     nbr_i;
    logic [NBR_W-1:0]     nbr_j;
    logic                 commit;
    logic                 emit;
    logic                 clr_we;
    logic [ADDR_BITS-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- design/pdd_ram.sv -----
`default_nettype none
module pdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/pdd_ctrl.sv -----
`default_nettype none
`include "poisson_disk_dart_check_defines.svh"
module pdd_ctrl
  import pdd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_op,
  input  wire stat_t st,
  output logic       in_stall,
  output cmd_t       cmd
);

  localparam int STEP_W = $clog2(DIV_STEPS > DRAIN_CYC ? DIV_STEPS : DRAIN_CYC);
  localparam logic [STEP_W-1:0]    DIV_LAST   = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0]    DRAIN_LAST = STEP_W'(DRAIN_CYC - 1);
  localparam logic [ADDR_BITS-1:0] ADDR_LAST  = ADDR_BITS'(CELLS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESULT
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [NBR_W-1:0]     si_r, si_nxt;
  logic [NBR_W-1:0]     sj_r, sj_nxt;
  logic                 report_r, report_nxt;

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    step_nxt   = step_r;
    si_nxt     = si_r;
    sj_nxt     = sj_r;
    report_nxt = report_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we   = 1'b1;
        cmd.clr_addr = addr_r;
        addr_nxt     = addr_r + 1'b1;
        if (addr_r == ADDR_LAST) begin
          addr_nxt   = '0;
          report_nxt = 1'b0;
          state_nxt  = report_r ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_op == OP_CLEAR) begin
            cmd.zero   = 1'b1;
            report_nxt = 1'b1;
            state_nxt  = ST_CLEAR;
          end else if (st.done) begin
            cmd.refuse = 1'b1;
            state_nxt  = ST_RESULT;
          end else begin
            cmd.start = 1'b1;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          si_nxt    = '0;
          sj_nxt    = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        cmd.nbr_i = si_r;
        cmd.nbr_j = sj_r;
        if (sj_r == NBR_LAST) begin
          sj_nxt = '0;
          if (si_r == NBR_LAST) begin
            step_nxt  = '0;
            state_nxt = ST_DRAIN;
          end else begin
            si_nxt = si_r + 1'b1;
          end
        end else begin
          sj_nxt = sj_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == DRAIN_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      addr_r   <= '0;
      step_r   <= '0;
      si_r     <= '0;
      sj_r     <= '0;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      step_r   <= step_nxt;
      si_r     <= si_nxt;
      sj_r     <= sj_nxt;
      report_r <= report_nxt;
    end
  end

  `PDD_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_r != ST_IDLE)
  `PDD_ASSERT_NOW(a_sweep_in_range, state_r == ST_CLEAR, addr_r <= ADDR_LAST)

endmodule
`default_nettype wire

// ----- design/pdd_dp.sv -----
`default_nettype none
`include "poisson_disk_dart_check_defines.svh"
module pdd_dp
  import pdd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic [COORD_W-1:0] cand_x,
  input  wire logic [COORD_W-1:0] cand_y,
  input  wire cmd_t               cmd,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output out_item_t               out_data,
  output stat_t                   st
);

  localparam logic [CELL_BITS:0] OFS_LO = (CELL_BITS + 1)'(NBR_OFS);
  localparam logic [CELL_BITS:0] OFS_HI = (CELL_BITS + 1)'(GRID_DIM + NBR_OFS);

  function automatic logic [LEN_W:0] div_bit(input logic [LEN_W-1:0] rem,
                                             input logic             b,
                                             input logic [LEN_W-1:0] d);
    logic [LEN_W:0] sh;
    logic [LEN_W:0] diff;
    sh   = {rem, b};
    diff = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      div_bit = {1'b1, diff[LEN_W-1:0]};
    end else begin
      div_bit = {1'b0, sh[LEN_W-1:0]};
    end
  endfunction

  function automatic logic [CELL_BITS-1:0] sat_cell(input logic [QUO_W-1:0] q,
                                                    input logic             dz);
    if (dz || q > QUO_W'(GRID_DIM - 1)) begin
      sat_cell = CELL_BITS'(GRID_DIM - 1);
    end else begin
      sat_cell = q[CELL_BITS-1:0];
    end
  endfunction

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [CELL_BITS-1:0] i,
                                                     input logic [CELL_BITS-1:0] j);
    cell_addr = ADDR_BITS'(ADDR_BITS'(i) * ADDR_BITS'(GRID_DIM)) + ADDR_BITS'(j);
  endfunction

  logic [COORD_BITS-1:0] cx_r, cy_r;
  logic [QUO_W-1:0]      dvd_x_r, dvd_y_r, quo_x_r, quo_y_r;
  logic [LEN_W-1:0]      rem_x_r, rem_y_r;
  logic [R2_W-1:0]       r2_r;
  logic [SQ_W-1:0]       sqx_r, sqy_r;
  logic                  v1_r, v2_r, close_r;
  logic [IDX_W-1:0]      acc_cnt_r, idx_r;
  logic [LIM_W-1:0]      rej_cnt_r;
  logic                  acc_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [LEN_W:0]        t1x, t2x, t1y, t2y;
  logic                  dz;
  logic [CELL_BITS-1:0]  gx, gy;
  logic [CELL_BITS:0]    ni, nj, ni_sub, nj_sub;
  logic                  nbr_ok;
  logic [ADDR_BITS-1:0]  own_addr, nbr_addr;
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic                  rd_valid;
  logic [COORD_BITS-1:0] rd_x, rd_y, dx, dy;
  logic [SQ_W-1:0]       sqx, sqy;
  logic [SUM_W-1:0]      dist2;
  logic                  hit;
  logic                  done;

  always_comb begin
    t1x = div_bit(rem_x_r, dvd_x_r[QUO_W-1], cfg.cell_side_fp);
    t2x = div_bit(t1x[LEN_W-1:0], dvd_x_r[QUO_W-2], cfg.cell_side_fp);
    t1y = div_bit(rem_y_r, dvd_y_r[QUO_W-1], cfg.cell_side_fp);
    t2y = div_bit(t1y[LEN_W-1:0], dvd_y_r[QUO_W-2], cfg.cell_side_fp);
  end

  assign dz       = (cfg.cell_side_fp == '0);
  assign gx       = sat_cell(quo_x_r, dz);
  assign gy       = sat_cell(quo_y_r, dz);
  assign own_addr = cell_addr(gx, gy);

  assign ni       = {1'b0, gx} + (CELL_BITS + 1)'(cmd.nbr_i);
  assign nj       = {1'b0, gy} + (CELL_BITS + 1)'(cmd.nbr_j);
  assign ni_sub   = ni - OFS_LO;
  assign nj_sub   = nj - OFS_LO;
  assign nbr_ok   = (ni >= OFS_LO) && (ni < OFS_HI) && (nj >= OFS_LO) && (nj < OFS_HI);
  assign nbr_addr = cell_addr(ni_sub[CELL_BITS-1:0], nj_sub[CELL_BITS-1:0]);

  assign ram_we    = cmd.clr_we || (cmd.commit && !close_r);
  assign ram_waddr = cmd.clr_we ? cmd.clr_addr : own_addr;
  assign ram_wdata = cmd.clr_we ? '0 : {1'b1, cx_r, cy_r};

  pdd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(nbr_addr),
    .rdata(ram_rdata)
  );

  assign {rd_valid, rd_x, rd_y} = ram_rdata;
  assign dx    = (rd_x > cx_r) ? (rd_x - cx_r) : (cx_r - rd_x);
  assign dy    = (rd_y > cy_r) ? (rd_y - cy_r) : (cy_r - rd_y);
  assign sqx   = SQ_W'(dx) * SQ_W'(dx);
  assign sqy   = SQ_W'(dy) * SQ_W'(dy);
  assign dist2 = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  assign hit   = v2_r && (dist2 < SUM_W'(r2_r));
  assign done  = (rej_cnt_r > cfg.reject_limit);

  assign st.done     = done;
  assign st.out_free = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      close_r     <= 1'b0;
      acc_cnt_r   <= '0;
      rej_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan && nbr_ok;
      v2_r <= v1_r && rd_valid;
      if (cmd.start) begin
        close_r <= 1'b0;
      end else if (hit) begin
        close_r <= 1'b1;
      end
      if (cmd.zero) begin
        acc_cnt_r <= '0;
        rej_cnt_r <= '0;
      end else if (cmd.commit) begin
        if (close_r) begin
          if (rej_cnt_r != REJ_MAX) begin
            rej_cnt_r <= rej_cnt_r + 1'b1;
          end
        end else begin
          rej_cnt_r <= '0;
          if (acc_cnt_r != CNT_MAX) begin
            acc_cnt_r <= acc_cnt_r + 1'b1;
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cx_r    <= COORD_BITS'(cand_x);
      cy_r    <= COORD_BITS'(cand_y);
      dvd_x_r <= QUO_W'(COORD_BITS'(cand_x));
      dvd_y_r <= QUO_W'(COORD_BITS'(cand_y));
      rem_x_r <= '0;
      rem_y_r <= '0;
      quo_x_r <= '0;
      quo_y_r <= '0;
      r2_r    <= R2_W'(cfg.radius_fp) * R2_W'(cfg.radius_fp);
    end else if (cmd.div_step) begin
      dvd_x_r <= dvd_x_r << 2;
      dvd_y_r <= dvd_y_r << 2;
      rem_x_r <= t2x[LEN_W-1:0];
      rem_y_r <= t2y[LEN_W-1:0];
      quo_x_r <= {quo_x_r[QUO_W-3:0], t1x[LEN_W], t2x[LEN_W]};
      quo_y_r <= {quo_y_r[QUO_W-3:0], t1y[LEN_W], t2y[LEN_W]};
    end
    sqx_r <= sqx;
    sqy_r <= sqy;
    if (cmd.zero) begin
      acc_r <= 1'b0;
      idx_r <= '0;
    end else if (cmd.refuse) begin
      acc_r <= 1'b0;
      idx_r <= acc_cnt_r;
    end else if (cmd.commit) begin
      acc_r <= !close_r;
      idx_r <= acc_cnt_r;
    end
    if (cmd.emit) begin
      out_data_r.accepted    <= acc_r;
      out_data_r.point_index <= idx_r;
      out_data_r.reject_run  <= rej_cnt_r;
      out_data_r.done_res    <= done;
    end
  end

  `PDD_ASSERT_NOW(a_accept_clears_run, cmd.emit && acc_r, rej_cnt_r == '0)
  `PDD_ASSERT_NOW(a_commit_not_done, cmd.commit, !done)
  `PDD_ASSERT_NOW(a_entry_follows_issue, v2_r, $past(v1_r))

endmodule
`default_nettype wire

// ----- design/poisson_disk_dart_check.sv -----
// Poisson-disk dart-throwing acceptance check on a grid of single-point cells.
// Input channel in_valid/in_stall/in_data: op selects a clear or a candidate
// (cand_x, cand_y in Q9.7). Output channel out_valid/out_stall/out_data gives
// exactly one result transaction per input transaction. The cfg_we/cfg_idx/
// cfg_wdata port writes radius, cell side and reject limit; the user must do
// so only while idle, as the block itself does not enforce it. Candidates are
// taken one at a time, input stalled until the result is loaded. Steps: a
// two-bit-per-cycle divider for the cell index, reading the 5x5 neighbor cells
// through one read port of the point store, the squared-distance test through
// the store read and squared-difference registers, a write-back of an accepted
// point and an output load. A candidate refused after done goes straight to
// its result. A clear sweeps all cells of the store, one per cycle, before its
// result appears. After reset the same sweep runs with in_stall held high.
// The result sits in an output register; while it is stalled the block keeps
// working, but the next result waits and further input is stalled.
`default_nettype none
module poisson_disk_dart_check
  import pdd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [LIM_W-1:0]     cfg_wdata
);

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius_fp    <= RADIUS_RST;
      cfg_r.cell_side_fp <= CELL_SIDE_RST;
      cfg_r.reject_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RADIUS: begin
          cfg_r.radius_fp <= cfg_wdata[LEN_W-1:0];
        end
        CFG_CELL_SIDE: begin
          cfg_r.cell_side_fp <= cfg_wdata[LEN_W-1:0];
        end
        CFG_REJECT_LIMIT: begin
          cfg_r.reject_limit <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  pdd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_op   (in_data.op),
    .st      (st),
    .in_stall(in_stall),
    .cmd     (cmd)
  );

  pdd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cand_x   (in_data.cand_x),
    .cand_y   (in_data.cand_y),
    .cmd      (cmd),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .st       (st)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top;
  import pdd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYC  = 600;
  localparam int TAIL_CYC  = 60;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 150;

  typedef struct packed {
    logic      is_cfg;
    in_item_t  item;
    cfg_t      cfg;
    logic      typed;
    out_item_t res;
  } plan_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_RADIUS;
  logic [LIM_W-1:0]     cfg_wdata = '0;

  cfg_t                  cfg_now;
  logic                  grid_used [CELLS];
  logic [COORD_BITS-1:0] grid_x [CELLS];
  logic [COORD_BITS-1:0] grid_y [CELLS];
  logic [IDX_W-1:0]      point_count;
  logic [LIM_W-1:0]      miss_run;
  logic [31:0]           placed_q [$];
  out_item_t             outcome_q [$];

  int send_idle  = 34;
  int recv_idle  = 67;
  int burst_left = 0;
  int bad_count  = 0;
  bit hold_req   = 1'b0;

  poisson_disk_dart_check uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void wipe_grid();
    int k;
    for (k = 0; k < CELLS; k++) begin
      grid_used[k] = 1'b0;
    end
    point_count = '0;
    miss_run = '0;
    placed_q.delete();
  endfunction

  function automatic int grid_cell(int unsigned coord);
    int unsigned q;
    if (cfg_now.cell_side_fp == '0) begin
      return GRID_DIM - 1;
    end
    q = coord / cfg_now.cell_side_fp;
    if (q > GRID_DIM - 1) begin
      q = GRID_DIM - 1;
    end
    return int'(q);
  endfunction

  function automatic bit near_point(int cx, int cy, int gx, int gy);
    longint r2;
    longint dx;
    longint dy;
    int i;
    int j;
    int k;
    r2 = longint'(cfg_now.radius_fp) * longint'(cfg_now.radius_fp);
    for (i = gx - 2; i <= gx + 2; i++) begin
      if (i < 0 || i >= GRID_DIM) continue;
      for (j = gy - 2; j <= gy + 2; j++) begin
        if (j < 0 || j >= GRID_DIM) continue;
        k = i * GRID_DIM + j;
        if (!grid_used[k]) continue;
        dx = longint'(grid_x[k]) - longint'(cx);
        dy = longint'(grid_y[k]) - longint'(cy);
        if (dx * dx + dy * dy < r2) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t dart_outcome(in_item_t it);
    out_item_t r;
    int cx;
    int cy;
    int gx;
    int gy;
    int k;
    r = '0;
    if (it.op == OP_CLEAR) begin
      wipe_grid();
    end else if (miss_run > cfg_now.reject_limit) begin
      r.point_index = point_count;
    end else begin
      cx = int'(it.cand_x[COORD_BITS-1:0]);
      cy = int'(it.cand_y[COORD_BITS-1:0]);
      gx = grid_cell(cx);
      gy = grid_cell(cy);
      r.point_index = point_count;
      if (near_point(cx, cy, gx, gy)) begin
        if (miss_run != REJ_MAX) miss_run = miss_run + 1'b1;
      end else begin
        k = gx * GRID_DIM + gy;
        grid_used[k] = 1'b1;
        grid_x[k] = cx[COORD_BITS-1:0];
        grid_y[k] = cy[COORD_BITS-1:0];
        r.accepted = 1'b1;
        if (point_count != CNT_MAX) point_count = point_count + 1'b1;
        miss_run = '0;
        placed_q.insert(placed_q.size(), {cx[15:0], cy[15:0]});
      end
    end
    r.reject_run = miss_run;
    r.done_res = (miss_run > cfg_now.reject_limit);
    return r;
  endfunction

  function automatic in_item_t next_dart();
    in_item_t it;
    logic [31:0] pick;
    int span;
    int px;
    int py;
    int roll;
    it = '0;
    it.op = OP_CAND;
    roll = $urandom_range(99);
    if (placed_q.size() > 0 && (burst_left > 0 || roll < 55)) begin
      if (burst_left > 0) begin
        burst_left--;
        span = int'(cfg_now.radius_fp) / 2;
      end else begin
        span = int'(cfg_now.radius_fp) + 64;
      end
      pick = placed_q[$urandom_range(placed_q.size() - 1)];
      px = int'(pick[31:16]) + int'($urandom_range(2 * span)) - span;
      py = int'(pick[15:0]) + int'($urandom_range(2 * span)) - span;
      if (px < 0) px = 0;
      if (py < 0) py = 0;
      if (px > 65535) px = 65535;
      if (py > 65535) py = 65535;
      it.cand_x = px[15:0];
      it.cand_y = py[15:0];
    end else if (roll < 85) begin
      it.cand_x = COORD_W'($urandom_range(44800));
      it.cand_y = COORD_W'($urandom_range(44800));
    end else begin
      it.cand_x = COORD_W'($urandom);
      it.cand_y = COORD_W'($urandom);
    end
    return it;
  endfunction

  function automatic out_item_t outcome(logic acc, int idx, int run, logic done);
    out_item_t r;
    r.accepted = acc;
    r.point_index = idx[IDX_W-1:0];
    r.reject_run = run[LIM_W-1:0];
    r.done_res = done;
    return r;
  endfunction

  function automatic plan_row_t dart_row(logic op, int x, int y);
    plan_row_t row;
    row = '0;
    row.item.op = op;
    row.item.cand_x = x[15:0];
    row.item.cand_y = y[15:0];
    return row;
  endfunction

  function automatic plan_row_t known_row(logic op, int x, int y, out_item_t res);
    plan_row_t row;
    row = dart_row(op, x, y);
    row.typed = 1'b1;
    row.res = res;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(int r, int s, int l);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg.radius_fp = r[LEN_W-1:0];
    row.cfg.cell_side_fp = s[LEN_W-1:0];
    row.cfg.reject_limit = l[LIM_W-1:0];
    return row;
  endfunction

  task automatic push_dart(input in_item_t it, input logic typed, input out_item_t known);
    int gap;
    out_item_t res;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = dart_outcome(it);
    outcome_q.insert(outcome_q.size(), typed ? known : res);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  task automatic load_cfg(input cfg_t c);
    int k;
    for (k = 0; k < 3; k++) begin
      cfg_we <= 1'b1;
      case (k)
        0: begin
          cfg_idx <= CFG_RADIUS;
          cfg_wdata <= LIM_W'(c.radius_fp);
        end
        1: begin
          cfg_idx <= CFG_CELL_SIDE;
          cfg_wdata <= LIM_W'(c.cell_side_fp);
        end
        default: begin
          cfg_idx <= CFG_REJECT_LIMIT;
          cfg_wdata <= c.reject_limit;
        end
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYC; n++) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (outcome_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("unexpected result: acc=%0d idx=%0d run=%0d done=%0d",
                   out_data.accepted, out_data.point_index, out_data.reject_run,
                   out_data.done_res);
        end
      end else begin
        want = outcome_q.pop_front();
        if (out_data.accepted !== want.accepted || out_data.point_index !== want.point_index
            || out_data.reject_run !== want.reject_run
            || out_data.done_res !== want.done_res) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("mismatch: expected acc=%0d idx=%0d run=%0d done=%0d",
                     want.accepted, want.point_index, want.reject_run, want.done_res);
            $display("          actual   acc=%0d idx=%0d run=%0d done=%0d",
                     out_data.accepted, out_data.point_index, out_data.reject_run,
                     out_data.done_res);
          end
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];
    in_item_t  it;
    cfg_t      c;
    int        p;
    int        n;
    int        roll;
    cfg_now.radius_fp = RADIUS_RST;
    cfg_now.cell_side_fp = CELL_SIDE_RST;
    cfg_now.reject_limit = LIMIT_RST;
    wipe_grid();

    plan.insert(plan.size(), known_row(OP_CAND, 0, 0, outcome(1'b1, 0, 0, 1'b0)));
    plan.insert(plan.size(), known_row(OP_CAND, 0, 0, outcome(1'b0, 1, 1, 1'b0)));
    plan.insert(plan.size(), known_row(OP_CAND, 1279, 0, outcome(1'b0, 1, 2, 1'b0)));
    plan.insert(plan.size(), dart_row(OP_CAND, 1280, 0));
    plan.insert(plan.size(), dart_row(OP_CAND, 44800, 44800));
    plan.insert(plan.size(), dart_row(OP_CAND, 65535, 65535));
    plan.insert(plan.size(), dart_row(OP_CAND, 65535, 0));
    plan.insert(plan.size(), dart_row(OP_CAND, 16'h5555, 16'hAAAA));
    plan.insert(plan.size(), dart_row(OP_CAND, 16'hAAAA, 16'h5555));
    plan.insert(plan.size(), known_row(OP_CLEAR, 65535, 65535, outcome(1'b0, 0, 0, 1'b0)));
    plan.insert(plan.size(), cfg_row(1280, 905, 0));
    plan.insert(plan.size(), known_row(OP_CAND, 3000, 3000, outcome(1'b1, 0, 0, 1'b0)));
    plan.insert(plan.size(), known_row(OP_CAND, 3000, 3000, outcome(1'b0, 1, 1, 1'b1)));
    plan.insert(plan.size(), known_row(OP_CAND, 20000, 20000, outcome(1'b0, 1, 1, 1'b1)));
    plan.insert(plan.size(), known_row(OP_CLEAR, 0, 0, outcome(1'b0, 0, 0, 1'b0)));
    plan.insert(plan.size(), cfg_row(2047, 0, 262143));
    plan.insert(plan.size(), dart_row(OP_CAND, 100, 100));
    plan.insert(plan.size(), dart_row(OP_CAND, 40000, 40000));
    plan.insert(plan.size(), dart_row(OP_CAND, 40100, 40000));
    plan.insert(plan.size(), cfg_row(0, 2047, 1));
    plan.insert(plan.size(), dart_row(OP_CAND, 500, 500));
    plan.insert(plan.size(), dart_row(OP_CAND, 500, 500));
    plan.insert(plan.size(), known_row(OP_CLEAR, 0, 0, outcome(1'b0, 0, 0, 1'b0)));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        load_cfg(plan[i].cfg);
      end else begin
        push_dart(plan[i].item, plan[i].typed, plan[i].res);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          c.radius_fp = RADIUS_RST;
          c.cell_side_fp = CELL_SIDE_RST;
          c.reject_limit = LIMIT_RST;
        end
        1: begin
          c.radius_fp = 11'd1024;
          c.cell_side_fp = 11'd724;
          c.reject_limit = 18'd3;
        end
        2: begin
          c.radius_fp = 11'd1664;
          c.cell_side_fp = 11'd1177;
          c.reject_limit = 18'd262143;
        end
        3: begin
          c.radius_fp = LEN_W'($urandom_range(1664, 1024));
          c.cell_side_fp = LEN_W'((int'(c.radius_fp) * 181) >> 8);
          c.reject_limit = LIM_W'($urandom_range(8));
        end
        4: begin
          c.radius_fp = 11'd1664;
          c.cell_side_fp = 11'd724;
          c.reject_limit = '0;
        end
        default: begin
          c.radius_fp = LEN_W'($urandom_range(2047));
          c.cell_side_fp = LEN_W'($urandom_range(2047));
          c.reject_limit = LIM_W'($urandom_range(20));
        end
      endcase
      load_cfg(c);
      send_idle = (p < 2) ? 34 : (p < 4) ? 67 : 0;
      recv_idle = (p < 2) ? 67 : (p < 4) ? 34 : 0;
      for (n = 0; n < PHASE_LEN; n++) begin
        if ((p == 1 || p == 4) && n == 40) hold_req = 1'b1;
        if (p == 3 && n == 75) wait_idle();
        roll = $urandom_range(99);
        if (roll < 2 || (miss_run > cfg_now.reject_limit && roll < 15)) begin
          it.op = OP_CLEAR;
          it.cand_x = COORD_W'($urandom);
          it.cand_y = COORD_W'($urandom);
        end else begin
          if (burst_left == 0 && $urandom_range(99) < 6) burst_left = $urandom_range(10, 4);
          it = next_dart();
        end
        push_dart(it, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (TAIL_CYC) @(posedge clk);
    if (bad_count == 0) begin
      $display("** poisson_disk_dart_check: PASSED **");
    end else begin
      $display("** poisson_disk_dart_check: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("** poisson_disk_dart_check: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/pdd_pkg.sv
design/pdd_ram.sv
design/pdd_ctrl.sv
design/pdd_dp.sv
design/poisson_disk_dart_check.sv
tb/sv/tb_top.sv
